### hdl/tlv_frame_checker_assert.svh
// Assertion macros used by the port-level checker of the TLV frame checker.
`ifndef TLV_FRAME_CHECKER_ASSERT_SVH
`define TLV_FRAME_CHECKER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TLVFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same, but also checked while reset is held.
`define TLVFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/tlvfc_pkg.sv
// Package with types and constants of the TLV frame checker.
`timescale 1ns / 1ps

package tlvfc_pkg;

    localparam int ID_BYTES = 16;

    localparam logic [7:0]  HDR_HI          = 8'hFC;
    localparam logic [7:0]  HDR_LO          = 8'hCD;
    localparam logic [7:0]  FRAME_TAG       = 8'd1;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_TOP         = 16'h8000;
    localparam logic [15:0] BUF_SIZE_RESET  = 16'd64;

    localparam logic [5:0] POS_HDR_HI = 6'd0;
    localparam logic [5:0] POS_HDR_LO = 6'd1;
    localparam logic [5:0] POS_TAG    = 6'd2;
    localparam logic [5:0] POS_LEN_LO = 6'd3;
    localparam logic [5:0] POS_LEN_HI = 6'd4;
    localparam logic [5:0] POS_TIME   = 6'd5;
    localparam logic [5:0] POS_ID     = 6'd11;
    localparam logic [5:0] POS_TEMP   = 6'(11 + ID_BYTES);
    localparam logic [5:0] POS_CRC    = 6'(13 + ID_BYTES);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_HDR = 3'd1,
        ST_BAD_TAG = 3'd2,
        ST_BAD_LEN = 3'd3,
        ST_BAD_CRC = 3'd4
    } t_status;

    typedef enum logic {
        KIND_ID     = 1'b0,
        KIND_REPORT = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_beat;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] id_byte;
        t_status    status;
        logic [7:0] year_offset;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
        logic [7:0] temp_int;
        logic [7:0] temp_hundredths;
    } t_out_beat;

endpackage

### hdl/tlvfc_crc_step.sv
// One-byte update of the CRC-16 (poly 0x1021, MSB first).
`timescale 1ns / 1ps

module tlvfc_crc_step
    import tlvfc_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

### hdl/tlv_frame_checker.sv
// Top level of the TLV frame checker: parser state, CRC and result register.
`timescale 1ns / 1ps

// Takes one frame byte per beat and parses it in the cycle it is accepted: header,
// tag, length check against buffer_size, time bytes, device id bytes (each passed
// on as a kind 0 result), temperature bytes, and the CRC-16 trailer, ending in one
// kind 1 report; the first error gives an early report and bytes are then dropped
// until the next frame_start. Throughput is one byte per clock: o_in_ready is high
// whenever the result register is empty or its beat is taken in the same cycle, so
// the rate is set only by the output side. The result is registered. The byte-wide
// CRC update is the longest path. buffer_size is written via the always-ready cfg
// channel; the user must do so only while the block is idle; it is not enforced.
module tlv_frame_checker
    import tlvfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_beat   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_beat  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_buf_size;
    logic [5:0]  r_pos,   n_pos;
    logic [15:0] r_crc,   n_crc;
    logic        r_disc,  n_disc;
    logic [7:0]  r_held,  n_held;
    logic [7:0]  r_time [6];
    logic [7:0]  r_temp [2];
    logic        r_out_valid, n_out_valid;
    t_out_beat   r_out_data,  n_out_data;

    logic        in_acc;
    logic        wr_time, wr_temp;
    logic [2:0]  time_idx;
    logic        temp_idx;
    logic [15:0] crc_cur, crc_upd;
    logic [5:0]  pos;
    logic        hit;
    t_out_beat   res;
    logic [16:0] len_sum;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign crc_cur = i_in_data.frame_start ? CRC_INIT : r_crc;
    assign pos     = i_in_data.frame_start ? 6'd0 : r_pos;
    assign len_sum = {1'b0, i_in_data.data_byte, r_held} + 17'd5;

    tlvfc_crc_step u_crc (
        .i_crc  (crc_cur),
        .i_byte (i_in_data.data_byte),
        .o_crc  (crc_upd)
    );

    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_disc   = r_disc;
        n_held   = r_held;
        wr_time  = 1'b0;
        wr_temp  = 1'b0;
        time_idx = 3'(pos - POS_TIME);
        temp_idx = 1'(pos - POS_TEMP);
        hit      = 1'b0;
        res      = '0;
        if (in_acc && (i_in_data.frame_start || !r_disc)) begin
            n_disc = 1'b0;
            n_pos  = pos + 6'd1;
            n_crc  = (pos < POS_CRC) ? crc_upd : crc_cur;
            res.kind = KIND_REPORT;
            if (pos == POS_HDR_HI) begin
                n_held = i_in_data.data_byte;
            end else if (pos == POS_HDR_LO) begin
                if (r_held != HDR_HI || i_in_data.data_byte != HDR_LO) begin
                    hit        = 1'b1;
                    res.status = ST_BAD_HDR;
                end
            end else if (pos == POS_TAG) begin
                if (i_in_data.data_byte != FRAME_TAG) begin
                    hit        = 1'b1;
                    res.status = ST_BAD_TAG;
                end
            end else if (pos == POS_LEN_LO) begin
                n_held = i_in_data.data_byte;
            end else if (pos == POS_LEN_HI) begin
                if (len_sum > {1'b0, r_buf_size}) begin
                    hit        = 1'b1;
                    res.status = ST_BAD_LEN;
                end
            end else if (pos < POS_ID) begin
                wr_time = 1'b1;
            end else if (pos < POS_TEMP) begin
                hit         = 1'b1;
                res.kind    = KIND_ID;
                res.id_byte = i_in_data.data_byte;
            end else if (pos < POS_CRC) begin
                wr_temp = 1'b1;
            end else if (pos == POS_CRC) begin
                n_held = i_in_data.data_byte;
            end else begin
                hit                 = 1'b1;
                res.status          = ({r_held, i_in_data.data_byte} == r_crc) ?
                                      ST_OK : ST_BAD_CRC;
                res.year_offset     = r_time[0];
                res.month           = r_time[1];
                res.day             = r_time[2];
                res.hour            = r_time[3];
                res.minute          = r_time[4];
                res.second          = r_time[5];
                res.temp_int        = r_temp[0];
                res.temp_hundredths = r_temp[1];
            end
            if (hit && res.kind == KIND_REPORT) begin
                n_disc = 1'b1;
            end
        end
        n_out_valid = (r_out_valid && !i_out_ready) || hit;
        n_out_data  = hit ? res : r_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_size  <= BUF_SIZE_RESET;
            r_pos       <= 6'd0;
            r_crc       <= CRC_INIT;
            r_disc      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_buf_size <= i_cfg_data;
            end
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_disc      <= n_disc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held     <= n_held;
        r_out_data <= n_out_data;
        if (wr_time) begin
            r_time[time_idx] <= i_in_data.data_byte;
        end
        if (wr_temp) begin
            r_temp[temp_idx] <= i_in_data.data_byte;
        end
    end

endmodule

### hdl/tlvfc_checker.sv
// Port-level checker of the TLV frame checker and its bind.
`timescale 1ns / 1ps
`include "tlv_frame_checker_assert.svh"

module tlvfc_checker
    import tlvfc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input t_in_beat   i_in_data,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out_beat  o_out_data,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic [15:0] i_cfg_data
);

    `TLVFC_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result beat dropped or changed while stalled")
    `TLVFC_ASSERT(a_out_cause, $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready), "result beat without an accepted input beat")
    `TLVFC_ASSERT(a_id_clean, o_out_valid && o_out_data.kind == KIND_ID |-> o_out_data.status == ST_OK && o_out_data.year_offset == 8'd0 && o_out_data.temp_int == 8'd0, "id beat carries report fields")
    `TLVFC_ASSERT(a_err_clean, o_out_valid && o_out_data.kind == KIND_REPORT && (o_out_data.status == ST_BAD_HDR || o_out_data.status == ST_BAD_TAG || o_out_data.status == ST_BAD_LEN) |-> o_out_data.id_byte == 8'd0 && o_out_data.second == 8'd0 && o_out_data.temp_hundredths == 8'd0, "early error report carries data")
    `TLVFC_ASSERT_ALWAYS(a_ready_when_empty, !o_out_valid && i_rst_n |-> o_in_ready, "input stalled with empty result register")

endmodule

bind tlv_frame_checker tlvfc_checker u_tlvfc_checker (.*);
